[rtl/tdps_pkg.sv]
// Shared types, constants and the cathode position table for the tube digit serializer.
package tdps_pkg;

  localparam int unsigned ValueW   = 20;
  localparam int unsigned FieldW   = 3;
  localparam int unsigned Tubes    = 6;
  localparam int unsigned NibbleW  = 4;
  localparam int unsigned Nibbles  = 16;
  localparam int unsigned PatternW = Nibbles * NibbleW;
  localparam int unsigned PosW     = 6;
  localparam int unsigned CntW     = 4;

  localparam logic [ValueW-1:0] ValueMax = 20'd999999;
  localparam logic [CntW-1:0]   LastNibble = 4'd15;

  // Pair codes: which tube pair goes dark.
  localparam logic [1:0] PairLeft  = 2'd0;
  localparam logic [1:0] PairMid   = 2'd1;
  localparam logic [1:0] PairRight = 2'd2;
  localparam logic [1:0] PairNone  = 2'd3;

  typedef struct packed {
    logic              blink;
    logic [FieldW-1:0] field;
  } ctl_t;

  typedef logic [Tubes-1:0][3:0] digits_t;

  function automatic logic [1:0] blank_pair(input logic [FieldW-1:0] field);
    logic [1:0] pair;
    case (field)
      3'd2, 3'd5: pair = PairLeft;
      3'd1, 3'd4: pair = PairMid;
      3'd0, 3'd3: pair = PairRight;
      default:    pair = PairNone;
    endcase
    return pair;
  endfunction

  // Bit position of the cathode that shows digit on tube; bit order within each nibble is reversed.
  function automatic logic [PosW-1:0] cathode_pos(input logic [2:0] tube,
                                                  input logic [3:0] digit);
    logic [6:0] base;
    logic [6:0] zero;
    logic [6:0] n;
    logic [6:0] p;
    case (tube)
      3'd0:    begin base = 7'd0;  zero = 7'd10; end
      3'd1:    begin base = 7'd10; zero = 7'd20; end
      3'd2:    begin base = 7'd20; zero = 7'd30; end
      3'd3:    begin base = 7'd34; zero = 7'd44; end
      3'd4:    begin base = 7'd44; zero = 7'd54; end
      default: begin base = 7'd54; zero = 7'd64; end
    endcase
    n = (digit == 4'd0) ? zero : base + {3'd0, digit};
    p = (n - 7'd1) ^ 7'd3;
    return p[PosW-1:0];
  endfunction

endpackage

[rtl/tdps_digit_split.sv]
// Five-stage pipeline: saturate, split by 1000, then hundreds, tens and units per half.
module tdps_digit_split (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tdps_pkg::ValueW-1:0]   value_i,
  input  tdps_pkg::ctl_t                ctl_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tdps_pkg::digits_t             digits_o,
  output tdps_pkg::ctl_t                ctl_o
);

  logic [4:0] vld_q;
  logic [4:0] adv;
  tdps_pkg::ctl_t ctl_q [5];

  // stage 1
  logic [19:0] sat_d, sat_q;
  logic [30:0] prod1;
  logic [10:0] q0_d, q0_q;
  // stage 2
  logic [20:0] rem2;
  logic [9:0]  hi_d, hi_q, lo_d, lo_q;
  // stage 3
  logic [15:0] ph_hi, ph_lo;
  logic [9:0]  x_hi_q, x_lo_q;
  logic [3:0]  h_hi_q, h_lo_q;
  // stage 4
  logic [9:0]  y_hi_w, y_lo_w;
  logic [6:0]  y_hi_q, y_lo_q;
  logic [3:0]  h_hi4_q, h_lo4_q;
  // stage 5
  logic [13:0] pt_hi, pt_lo;
  logic [3:0]  t_hi, t_lo;
  logic [6:0]  u_hi, u_lo;
  tdps_pkg::digits_t dig_d, dig_q;

  assign adv[4] = !vld_q[4] || out_ready_i;
  assign adv[3] = !vld_q[3] || adv[4];
  assign adv[2] = !vld_q[2] || adv[3];
  assign adv[1] = !vld_q[1] || adv[2];
  assign adv[0] = !vld_q[0] || adv[1];
  assign in_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < 5; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // q0 under-estimates v/1000 by at most one
  assign sat_d = (value_i > tdps_pkg::ValueMax) ? tdps_pkg::ValueMax : value_i;
  assign prod1 = {11'd0, sat_d} * 31'd1048;
  assign q0_d  = prod1[30:20];

  assign rem2 = {1'b0, sat_q} - ({10'd0, q0_q} * 21'd1000);
  always_comb begin
    if (rem2 >= 21'd1000) begin
      hi_d = q0_q[9:0] + 10'd1;
      lo_d = 10'(rem2 - 21'd1000);
    end else begin
      hi_d = q0_q[9:0];
      lo_d = rem2[9:0];
    end
  end

  assign ph_hi = {6'd0, hi_q} * 16'd41;
  assign ph_lo = {6'd0, lo_q} * 16'd41;

  assign y_hi_w = x_hi_q - ({6'd0, h_hi_q} * 10'd100);
  assign y_lo_w = x_lo_q - ({6'd0, h_lo_q} * 10'd100);

  assign pt_hi = {7'd0, y_hi_q} * 14'd103;
  assign pt_lo = {7'd0, y_lo_q} * 14'd103;
  assign t_hi  = pt_hi[13:10];
  assign t_lo  = pt_lo[13:10];
  assign u_hi  = y_hi_q - ({3'd0, t_hi} * 7'd10);
  assign u_lo  = y_lo_q - ({3'd0, t_lo} * 7'd10);

  always_comb begin
    dig_d[0] = h_hi4_q;
    dig_d[1] = t_hi;
    dig_d[2] = u_hi[3:0];
    dig_d[3] = h_lo4_q;
    dig_d[4] = t_lo;
    dig_d[5] = u_lo[3:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      sat_q    <= sat_d;
      q0_q     <= q0_d;
      ctl_q[0] <= ctl_i;
    end
    if (adv[1]) begin
      hi_q     <= hi_d;
      lo_q     <= lo_d;
      ctl_q[1] <= ctl_q[0];
    end
    if (adv[2]) begin
      x_hi_q   <= hi_q;
      x_lo_q   <= lo_q;
      h_hi_q   <= ph_hi[15:12];
      h_lo_q   <= ph_lo[15:12];
      ctl_q[2] <= ctl_q[1];
    end
    if (adv[3]) begin
      y_hi_q   <= y_hi_w[6:0];
      y_lo_q   <= y_lo_w[6:0];
      h_hi4_q  <= h_hi_q;
      h_lo4_q  <= h_lo_q;
      ctl_q[3] <= ctl_q[2];
    end
    if (adv[4]) begin
      dig_q    <= dig_d;
      ctl_q[4] <= ctl_q[3];
    end
  end

  assign out_valid_o = vld_q[4];
  assign digits_o    = dig_q;
  assign ctl_o       = ctl_q[4];

endmodule

[rtl/tdps_pattern.sv]
// Cathode lookup and blanking stage: builds the 64-bit tube pattern.
module tdps_pattern (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  tdps_pkg::digits_t               digits_i,
  input  tdps_pkg::ctl_t                  ctl_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tdps_pkg::PatternW-1:0]   pattern_o
);

  logic                            vld_q;
  logic [tdps_pkg::PatternW-1:0]   pat_d, pat_q;
  logic [1:0]                      dark;
  logic [tdps_pkg::PosW-1:0]       pos;

  assign in_ready_o = !vld_q || out_ready_i;
  assign dark = ctl_i.blink ? tdps_pkg::blank_pair(ctl_i.field) : tdps_pkg::PairNone;

  always_comb begin
    pat_d = '0;
    pos   = '0;
    for (int t = 0; t < tdps_pkg::Tubes; t++) begin
      pos = tdps_pkg::cathode_pos(3'(t), digits_i[t]);
      if (2'(t / 2) != dark) pat_d[pos] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) pat_q <= pat_d;
  end

  assign out_valid_o = vld_q;
  assign pattern_o   = pat_q;

endmodule

[rtl/tdps_nibble_ser.sv]
// Shifts a 64-bit pattern out as sixteen nibbles, low end first, flagging the last.
module tdps_nibble_ser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [tdps_pkg::PatternW-1:0]   pattern_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tdps_pkg::NibbleW-1:0]    data_nibble_o,
  output logic                            latch_last_o
);

  logic                            busy_q, busy_d;
  logic [tdps_pkg::CntW-1:0]       cnt_q, cnt_d;
  logic [tdps_pkg::PatternW-1:0]   shf_q, shf_d;
  logic                            last;
  logic                            xfer;
  logic                            load;

  assign last       = (cnt_q == tdps_pkg::LastNibble);
  assign xfer       = busy_q && out_ready_i;
  assign in_ready_o = !busy_q || (out_ready_i && last);
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    shf_d  = shf_q;
    if (load) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      shf_d  = pattern_i;
    end else if (xfer) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
        shf_d = shf_q >> tdps_pkg::NibbleW;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shf_q <= shf_d;
  end

  assign out_valid_o   = busy_q;
  assign data_nibble_o = shf_q[tdps_pkg::NibbleW-1:0];
  assign latch_last_o  = last;

  a_load_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> busy_q && cnt_q == '0)
    else $error("serializer did not restart count on load");

  a_idle_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == '0 || cnt_q == tdps_pkg::LastNibble)
    else $error("serializer idle with partial count");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && last && !in_valid_i) |=> !busy_q)
    else $error("serializer stayed busy after last transfer");

  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && !last) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("nibble count did not step on transfer");

endmodule

[rtl/tube_digit_pattern_serializer.sv]
// Top level: decimal split pipeline, pattern stage and four-line nibble serializer.
// Path to the first nibble: the five split stages, the first written at the input transfer edge,
// then the pattern stage, then the load into the shift register.
// The serializer emits one nibble a cycle while out_ready_i is high, sixteen per item,
// and takes the next item with the last nibble; up to six more wait in the pipeline stages.
// Reset: rst_ni is asynchronous, active low; it clears all valid bits and the nibble count.
module tube_digit_pattern_serializer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tdps_pkg::ValueW-1:0]    display_value_i,
  input  logic                           blink_phase_i,
  input  logic [tdps_pkg::FieldW-1:0]    edit_field_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tdps_pkg::NibbleW-1:0]   data_nibble_o,
  output logic                           latch_last_o
);

  tdps_pkg::ctl_t                  ctl_in, ctl_split;
  tdps_pkg::digits_t               digits;
  logic                            split_valid, split_ready;
  logic                            pat_valid, pat_ready;
  logic [tdps_pkg::PatternW-1:0]   pattern;

  assign ctl_in.blink = blink_phase_i;
  assign ctl_in.field = edit_field_i;

  tdps_digit_split u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (display_value_i),
    .ctl_i       (ctl_in),
    .out_valid_o (split_valid),
    .out_ready_i (split_ready),
    .digits_o    (digits),
    .ctl_o       (ctl_split)
  );

  tdps_pattern u_pattern (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (split_valid),
    .in_ready_o  (split_ready),
    .digits_i    (digits),
    .ctl_i       (ctl_split),
    .out_valid_o (pat_valid),
    .out_ready_i (pat_ready),
    .pattern_o   (pattern)
  );

  tdps_nibble_ser u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (pat_valid),
    .in_ready_o    (pat_ready),
    .pattern_i     (pattern),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .data_nibble_o (data_nibble_o),
    .latch_last_o  (latch_last_o)
  );

endmodule
